// ===== design/pid_filtered_clamped_macros.svh =====
// ----------------------------------------------------------------------------
// pid_filtered_clamped assertion macros
// Shared checks for the PID controller, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef PID_FILTERED_CLAMPED_MACROS_SVH
`define PID_FILTERED_CLAMPED_MACROS_SVH

// same-cycle implication
`define PFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pid_filtered_clamped check failed");

// next-cycle implication
`define PFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pid_filtered_clamped check failed");

`endif

// ===== design/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, constants and the control program of the PID controller.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int DW      = 32;
  localparam int LIM_W   = 31;
  localparam int CFG_AW  = 3;
  localparam int STEP_W  = 4;
  localparam int ERR_W   = 33;
  localparam int DLT_W   = 34;
  localparam int MA_W    = 33;
  localparam int MB_W    = 18;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = 68;
  localparam int SUM_W   = 47;
  localparam int RND_W   = 48;
  localparam int CHUNK   = 17;

  localparam logic signed [MB_W-1:0] W_NEW = 18'sd45875;
  localparam logic signed [MB_W-1:0] W_OLD = 18'sd19661;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE  = 4'd0;
  localparam step_t STEP_DRIVE = 4'd12;

  typedef enum logic [2:0] {
    REG_SETPOINT, REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_INT_LIMIT, REG_OUT_LIMIT
  } cfg_idx_t;

  typedef enum logic [2:0] {
    A_GP, A_GI, A_GD, A_SUM_LO, A_SUM_HI, A_DRV
  } a_sel_t;

  typedef enum logic [2:0] {
    B_ERR_LO, B_ERR_HI, B_DLT_LO, B_DLT_HI, B_WNEW, B_WOLD
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_ADD_SH
  } acc_op_t;

  typedef enum logic [1:0] {
    SUM_HOLD, SUM_LOAD_RND, SUM_ADD_INT, SUM_ADD_RND
  } sum_op_t;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_IN, STALL_OUT
  } stall_t;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    acc_op_t acc_op;
    sum_op_t sum_op;
    logic    dlt_we;
    logic    integ_we;
    logic    drv_we;
    stall_t  stall;
    logic    jump;
    step_t   target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_fire;
    logic out_busy;
  } seq_stat_t;

  function automatic ctrl_word_t prog_rom(input step_t s);
    ctrl_word_t w;
    w = '0;
    case (s)
      4'd0: begin
        w.stall = STALL_IN;
      end
      4'd1: begin
        w.a_sel = A_GP; w.b_sel = B_ERR_LO; w.dlt_we = 1'b1;
      end
      4'd2: begin
        w.a_sel = A_GP; w.b_sel = B_ERR_HI; w.acc_op = ACC_LOAD;
      end
      4'd3: begin
        w.a_sel = A_GI; w.b_sel = B_ERR_LO; w.acc_op = ACC_ADD_SH;
      end
      4'd4: begin
        w.a_sel = A_GI; w.b_sel = B_ERR_HI; w.acc_op = ACC_LOAD; w.sum_op = SUM_LOAD_RND;
      end
      4'd5: begin
        w.a_sel = A_GD; w.b_sel = B_DLT_LO; w.acc_op = ACC_ADD_SH;
      end
      4'd6: begin
        w.a_sel = A_GD; w.b_sel = B_DLT_HI; w.acc_op = ACC_LOAD; w.integ_we = 1'b1;
      end
      4'd7: begin
        w.a_sel = A_DRV; w.b_sel = B_WOLD; w.acc_op = ACC_ADD_SH; w.sum_op = SUM_ADD_INT;
      end
      4'd8: begin
        w.acc_op = ACC_LOAD; w.sum_op = SUM_ADD_RND;
      end
      4'd9: begin
        w.a_sel = A_SUM_LO; w.b_sel = B_WNEW;
      end
      4'd10: begin
        w.a_sel = A_SUM_HI; w.b_sel = B_WNEW; w.acc_op = ACC_ADD;
      end
      4'd11: begin
        w.acc_op = ACC_ADD_SH;
      end
      STEP_DRIVE: begin
        w.drv_we = 1'b1; w.stall = STALL_OUT; w.jump = 1'b1; w.target = STEP_IDLE;
      end
      default: begin
        w.jump = 1'b1; w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [DW-1:0] clamp_sym(input logic signed [RND_W-1:0] v,
                                                    input logic [LIM_W-1:0] lim);
    logic signed [RND_W-1:0] hi;
    logic signed [RND_W-1:0] lo;
    logic signed [RND_W-1:0] res;
    hi = {{(RND_W-LIM_W){1'b0}}, lim};
    lo = -hi;
    if (v > hi) res = hi;
    else if (v < lo) res = lo;
    else res = v;
    return res[DW-1:0];
  endfunction

endpackage

// ===== design/pfc_if.sv =====
// ----------------------------------------------------------------------------
// pfc_if
// Valid/ready channels for measurement items and drive items.
// ----------------------------------------------------------------------------
interface pfc_meas_if import pfc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

interface pfc_drive_if import pfc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

// ===== design/pfc_seq.sv =====
// ----------------------------------------------------------------------------
// pfc_seq
// Step counter and control ROM; holds on input and output waits.
// ----------------------------------------------------------------------------
module pfc_seq import pfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  seq_stat_t  stat,
  output ctrl_word_t ctrl,
  output logic       adv
);

  step_t step_r;
  step_t step_nxt;
  logic  hold;

  assign ctrl = prog_rom(step_r);

  always_comb begin
    case (ctrl.stall)
      STALL_IN:  hold = !stat.in_fire;
      STALL_OUT: hold = stat.out_busy;
      default:   hold = 1'b0;
    endcase
  end

  assign adv = !hold;

  always_comb begin
    if (hold) begin
      step_nxt = step_r;
    end else if (ctrl.jump) begin
      step_nxt = ctrl.target;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== design/pid_filtered_clamped.sv =====
// ----------------------------------------------------------------------------
// pid_filtered_clamped: PID controller with integral clamp and output blend
// Each measurement item is accepted in the idle step and runs a 13-step
// program on one shared 33x18 multiplier; no new item is accepted until the
// program is back in the idle step, and the drive step holds while the output
// is not taken. Synchronous reset clears configuration, sequencer and PID state.
`include "pid_filtered_clamped_macros.svh"

module pid_filtered_clamped import pfc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  pfc_meas_if.sink          in_meas,
  pfc_drive_if.source       out_drive,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [DW-1:0]     cfg_data
);

  logic signed [DW-1:0]    setpoint_r;
  logic signed [DW-1:0]    gain_p_r;
  logic signed [DW-1:0]    gain_i_r;
  logic signed [DW-1:0]    gain_d_r;
  logic [LIM_W-1:0]        ilim_r;
  logic [LIM_W-1:0]        olim_r;

  logic signed [ERR_W-1:0] err_r;
  logic signed [ERR_W-1:0] err_nxt;
  logic signed [ERR_W-1:0] prev_err_r;
  logic signed [DLT_W-1:0] dlt_r;
  logic signed [DLT_W-1:0] dlt_nxt;
  logic signed [DW-1:0]    integ_r;
  logic signed [DW-1:0]    integ_nxt;
  logic signed [DW-1:0]    prev_drive_r;
  logic signed [DW-1:0]    drive_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  rnd_sum;
  logic signed [RND_W-1:0]  rnd20;
  logic signed [RND_W-1:0]  blend;
  logic signed [RND_W-1:0]  integ_sum;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [DW-1:0]     olim_s;

  ctrl_word_t ctrl;
  seq_stat_t  stat;
  logic       adv;
  logic       in_ready;
  logic       in_fire;
  logic       drv_fire;

  // control

  assign in_ready      = (ctrl.stall == STALL_IN);
  assign in_fire       = in_meas.valid && in_ready;
  assign stat.in_fire  = in_fire;
  assign stat.out_busy = out_valid_r && !out_drive.ready;
  assign drv_fire      = ctrl.drv_we && adv;

  assign in_meas.ready   = in_ready;
  assign out_drive.valid = out_valid_r;
  assign out_drive.drive = prev_drive_r;

  pfc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl),
    .adv   (adv)
  );

  // configuration

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= '0;
      gain_p_r   <= '0;
      gain_i_r   <= '0;
      gain_d_r   <= '0;
      ilim_r     <= '0;
      olim_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SETPOINT:  setpoint_r <= cfg_data;
        REG_GAIN_P:    gain_p_r   <= cfg_data;
        REG_GAIN_I:    gain_i_r   <= cfg_data;
        REG_GAIN_D:    gain_d_r   <= cfg_data;
        REG_INT_LIMIT: ilim_r     <= cfg_data[LIM_W-1:0];
        REG_OUT_LIMIT: olim_r     <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operands

  always_comb begin
    case (ctrl.a_sel)
      A_GP:     mul_a = MA_W'(gain_p_r);
      A_GI:     mul_a = MA_W'(gain_i_r);
      A_GD:     mul_a = MA_W'(gain_d_r);
      A_SUM_LO: mul_a = {{(MA_W-CHUNK){1'b0}}, sum_r[CHUNK-1:0]};
      A_SUM_HI: mul_a = {{(MA_W-SUM_W+CHUNK){sum_r[SUM_W-1]}}, sum_r[SUM_W-1:CHUNK]};
      A_DRV:    mul_a = MA_W'(prev_drive_r);
      default:  mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl.b_sel)
      B_ERR_LO: mul_b = {1'b0, err_r[CHUNK-1:0]};
      B_ERR_HI: mul_b = {err_r[ERR_W-1], err_r[ERR_W-1], err_r[ERR_W-1:CHUNK]};
      B_DLT_LO: mul_b = {1'b0, dlt_r[CHUNK-1:0]};
      B_DLT_HI: mul_b = {dlt_r[DLT_W-1], dlt_r[DLT_W-1:CHUNK]};
      B_WNEW:   mul_b = W_NEW;
      B_WOLD:   mul_b = W_OLD;
      default:  mul_b = '0;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign prod_ext = ACC_W'(prod_r);

  // accumulate, round and clamp

  always_comb begin
    case (ctrl.acc_op)
      ACC_LOAD:   acc_nxt = prod_ext;
      ACC_ADD:    acc_nxt = acc_r + prod_ext;
      ACC_ADD_SH: acc_nxt = acc_r + (prod_ext <<< CHUNK);
      default:    acc_nxt = acc_r;
    endcase
  end

  assign rnd_sum = acc_r + (ctrl.drv_we ? ACC_W'(1 << 15) : ACC_W'(1 << 19));
  assign rnd20   = $signed(rnd_sum[ACC_W-1:20]);
  assign blend   = $signed(rnd_sum[RND_W+15:16]);

  always_comb begin
    case (ctrl.sum_op)
      SUM_LOAD_RND: sum_nxt = rnd20[SUM_W-1:0];
      SUM_ADD_INT:  sum_nxt = sum_r + SUM_W'(integ_r);
      SUM_ADD_RND:  sum_nxt = sum_r + rnd20[SUM_W-1:0];
      default:      sum_nxt = sum_r;
    endcase
  end

  assign integ_sum = RND_W'(integ_r) + rnd20;
  assign integ_nxt = clamp_sym(integ_sum, ilim_r);
  assign drive_nxt = clamp_sym(blend, olim_r);

  assign err_nxt = ERR_W'(setpoint_r) - ERR_W'(in_meas.measurement);
  assign dlt_nxt = DLT_W'(err_r) - DLT_W'(prev_err_r);

  always_comb begin
    if (drv_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_drive.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      err_r <= err_nxt;
    end
    if (adv) begin
      prod_r <= prod_nxt;
      acc_r  <= acc_nxt;
      sum_r  <= sum_nxt;
      if (ctrl.dlt_we) begin
        dlt_r <= dlt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r   <= '0;
      integ_r      <= '0;
      prev_drive_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (adv && ctrl.dlt_we) begin
        prev_err_r <= err_r;
      end
      if (adv && ctrl.integ_we) begin
        integ_r <= integ_nxt;
      end
      if (drv_fire) begin
        prev_drive_r <= drive_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // checks

  assign olim_s = DW'(olim_r);

  `PFC_ASSERT_IMP(a_drive_in_limit, out_valid_r, (prev_drive_r <= olim_s) && (prev_drive_r >= -olim_s))
  `PFC_ASSERT_IMP(a_drive_from_prog, $rose(out_valid_r), $past(drv_fire))
  `PFC_ASSERT_NXT(a_one_item, in_fire, !in_ready)

endmodule
